FILE: design/kpi_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe pose interpolator package
// Shared word types, control structs, default sizes and the walk keyframe
// table with its bounded lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package kpi_pkg;

  // Default sizes handed to the top level parameters.
  localparam int STEPS_PER_SEGMENT_DEF = 16;
  localparam int KEYFRAME_COUNT_DEF    = 8;
  localparam int CHANNEL_COUNT_DEF     = 21;

  // Size of the fixed keyframe table.
  localparam int ROM_ROWS = 8;
  localparam int ROM_COLS = 21;

  // Request codes carried in req_type.
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Input word.
  typedef struct packed {
    logic       req_type;
    logic [4:0] channel_sel;
    logic [7:0] write_value;
  } req_t;

  // Output word.
  typedef struct packed {
    logic [4:0] out_channel;
    logic [7:0] out_value;
    logic       last_of_pose;
    logic       walk_active;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // clear the channel counter for a new pose
    logic load;    // compute one channel into the output register
    logic commit;  // advance the substep and keyframe counters
  } kpi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;  // output register holds a word not yet taken
    logic last_ch;   // channel counter is on the final channel
  } kpi_sts_t;

  // Walk keyframes, one row per keyframe, one column per channel.
  localparam logic [7:0] KEYFRAME_ROM [ROM_ROWS][ROM_COLS] = '{
    '{8'd255, 8'd124, 8'd130, 8'd145, 8'd20, 8'd140, 8'd140, 8'd150, 8'd120, 8'd135,
      8'd124, 8'd125, 8'd140, 8'd254, 8'd110, 8'd132, 8'd120, 8'd128, 8'd125, 8'd128,
      8'd0},
    '{8'd255, 8'd134, 8'd130, 8'd145, 8'd20, 8'd140, 8'd130, 8'd150, 8'd120, 8'd135,
      8'd124, 8'd125, 8'd140, 8'd254, 8'd110, 8'd112, 8'd120, 8'd128, 8'd125, 8'd128,
      8'd0},
    '{8'd255, 8'd134, 8'd150, 8'd145, 8'd20, 8'd154, 8'd130, 8'd150, 8'd120, 8'd135,
      8'd124, 8'd135, 8'd140, 8'd254, 8'd120, 8'd118, 8'd120, 8'd128, 8'd125, 8'd128,
      8'd0},
    '{8'd255, 8'd124, 8'd150, 8'd145, 8'd20, 8'd154, 8'd170, 8'd150, 8'd120, 8'd135,
      8'd114, 8'd135, 8'd140, 8'd254, 8'd120, 8'd132, 8'd120, 8'd128, 8'd125, 8'd128,
      8'd0},
    '{8'd255, 8'd124, 8'd120, 8'd145, 8'd20, 8'd130, 8'd160, 8'd150, 8'd120, 8'd135,
      8'd114, 8'd105, 8'd140, 8'd254, 8'd130, 8'd122, 8'd120, 8'd128, 8'd125, 8'd128,
      8'd0},
    '{8'd255, 8'd134, 8'd120, 8'd145, 8'd20, 8'd130, 8'd140, 8'd150, 8'd120, 8'd135,
      8'd124, 8'd115, 8'd140, 8'd254, 8'd90, 8'd118, 8'd120, 8'd128, 8'd125, 8'd128,
      8'd0},
    '{8'd255, 8'd134, 8'd150, 8'd145, 8'd20, 8'd154, 8'd130, 8'd150, 8'd120, 8'd135,
      8'd124, 8'd135, 8'd140, 8'd254, 8'd120, 8'd118, 8'd120, 8'd128, 8'd125, 8'd128,
      8'd0},
    '{8'd255, 8'd124, 8'd130, 8'd145, 8'd20, 8'd140, 8'd140, 8'd150, 8'd120, 8'd135,
      8'd124, 8'd125, 8'd140, 8'd254, 8'd110, 8'd132, 8'd120, 8'd128, 8'd125, 8'd128,
      8'd0}
  };

  // Table lookup; any keyframe or channel outside the table reads as zero.
  function automatic logic [7:0] rom_at(input logic [6:0] kf, input logic [6:0] ch);
    logic [7:0] val;
    val = 8'd0;
    if ((kf < 7'(ROM_ROWS)) && (ch < 7'(ROM_COLS))) begin
      val = KEYFRAME_ROM[kf[2:0]][ch[4:0]];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: design/kpi_stream_if.sv
// ----------------------------------------------------------------------------
// Keyframe pose interpolator stream interface
// Valid/ready channel that carries one word of type T per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface kpi_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: design/kpi_ctrl.sv
// ----------------------------------------------------------------------------
// Keyframe pose interpolator controller
// Takes request words and sequences one pose, channel by channel, into the
// datapath's output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kpi_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_tick,
  output logic                  in_ready,
  input  wire logic             out_ready,
  input  wire kpi_pkg::kpi_sts_t sts,
  output kpi_pkg::kpi_cmd_t      cmd
);
  import kpi_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Request words are taken only between poses.
  assign in_ready = (state == ST_IDLE);

  // Command decode.
  always_comb begin
    cmd.start  = (state == ST_IDLE) && in_valid && in_tick;
    cmd.load   = (state == ST_RUN) && (!sts.out_busy || out_ready);
    cmd.commit = cmd.load && sts.last_ch;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_tick) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/kpi_datapath.sv
// ----------------------------------------------------------------------------
// Keyframe pose interpolator datapath
// Walk counters, one-channel interpolation unit and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kpi_datapath #(
  parameter int STEPS_PER_SEGMENT = kpi_pkg::STEPS_PER_SEGMENT_DEF,
  parameter int KEYFRAME_COUNT    = kpi_pkg::KEYFRAME_COUNT_DEF,
  parameter int CHANNEL_COUNT     = kpi_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kpi_pkg::kpi_cmd_t cmd,
  output kpi_pkg::kpi_sts_t      sts,
  kpi_stream_if.source           rsp
);
  import kpi_pkg::*;

  localparam int SS_W   = $clog2(STEPS_PER_SEGMENT);
  localparam int KF_W   = $clog2(KEYFRAME_COUNT);
  localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int PROD_W = SS_W + 10;

  logic [SS_W-1:0] substep_index;
  logic [KF_W-1:0] keyframe_index;
  logic            hold_final;
  logic [CH_W-1:0] ch;

  logic [SS_W-1:0] ss_next;
  logic [KF_W-1:0] kf_next;
  logic            hold_next;
  logic            active_next;

  logic [6:0]          ch_idx;
  logic [6:0]          kf_idx;
  logic [6:0]          kf_to_idx;
  logic [7:0]          base;
  logic [7:0]          target;
  logic signed [8:0]   diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] scaled;
  logic [7:0]          value;

  logic valid;
  rsp_t word;

  // Walk state after this tick; the final keyframe is held once at its last
  // substep, then the walk starts over.
  always_comb begin
    ss_next   = substep_index + SS_W'(1);
    kf_next   = keyframe_index;
    hold_next = hold_final;
    if (substep_index == SS_W'(STEPS_PER_SEGMENT - 1)) begin
      ss_next = '0;
      if (keyframe_index == KF_W'(KEYFRAME_COUNT - 1)) begin
        kf_next = '0;
      end else begin
        kf_next = keyframe_index + KF_W'(1);
      end
      if (kf_next == KF_W'(KEYFRAME_COUNT - 1)) begin
        ss_next   = SS_W'(STEPS_PER_SEGMENT - 1);
        hold_next = 1'b1;
      end else begin
        hold_next = 1'b0;
      end
    end
    active_next = ((ss_next != '0) && (ss_next != SS_W'(STEPS_PER_SEGMENT - 1))) ||
                  (kf_next != '0);
  end

  // One channel: base + floor(substep * diff / steps), the floor being an
  // arithmetic shift since the step count is a power of two.
  always_comb begin
    ch_idx    = 7'(ch);
    kf_idx    = 7'(keyframe_index);
    kf_to_idx = hold_final ? kf_idx : (kf_idx + 7'd1);
    base      = rom_at(kf_idx, ch_idx);
    target    = rom_at(kf_to_idx, ch_idx);
    diff      = $signed({1'b0, target}) - $signed({1'b0, base});
    prod      = PROD_W'($signed({1'b0, substep_index}) * diff);
    scaled    = prod >>> SS_W;
    value     = base + scaled[7:0];
  end

  assign sts.out_busy = valid;
  assign sts.last_ch  = (ch == CH_W'(CHANNEL_COUNT - 1));

  // Walk counters advance once the last channel of a pose is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      substep_index  <= '0;
      keyframe_index <= '0;
      hold_final     <= 1'b0;
    end else if (cmd.commit) begin
      substep_index  <= ss_next;
      keyframe_index <= kf_next;
      hold_final     <= hold_next;
    end
  end

  // Channel counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
    end else if (cmd.start) begin
      ch <= '0;
    end else if (cmd.load && !sts.last_ch) begin
      ch <= ch + CH_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word.out_channel  <= ch_idx[4:0];
      word.out_value    <= value;
      word.last_of_pose <= sts.last_ch;
      word.walk_active  <= active_next;
    end
  end

  assign rsp.valid   = valid;
  assign rsp.payload = word;

endmodule

`default_nettype wire

FILE: design/keyframe_pose_interpolator.sv
// ----------------------------------------------------------------------------
// Keyframe pose interpolator
// Steps a servo pose through a fixed walk keyframe table, one tick at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req carries request words. A tick word computes the next pose and sends
//   CHANNEL_COUNT words on rsp, channel 0 first, the last one flagged by
//   last_of_pose; all words of a pose share one walk_active flag taken from
//   the walk state after the tick. A write word is accepted and produces no
//   output, since the following tick recomputes every channel anyway.
//   Timing: an accepted tick moves the controller into its run state, from
//   which the first output word of a pose is loaded into the output
//   register; one channel follows per cycle while rsp takes each word, all
//   channels sharing the single interpolation unit. A new request is taken
//   in the cycle after the last channel is loaded, while that word still
//   waits in the output register, so the next tick can be taken before the
//   last word of a pose is read. When rsp stalls, the output register holds
//   its word and the channel sequence waits. Reset puts the walk at keyframe
//   0, substep 0, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_pose_interpolator #(
  parameter int STEPS_PER_SEGMENT = kpi_pkg::STEPS_PER_SEGMENT_DEF,
  parameter int KEYFRAME_COUNT    = kpi_pkg::KEYFRAME_COUNT_DEF,
  parameter int CHANNEL_COUNT     = kpi_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  kpi_stream_if.sink   req,
  kpi_stream_if.source rsp
);
  import kpi_pkg::*;

  kpi_cmd_t cmd;
  kpi_sts_t sts;
  logic     in_ready;
  logic     in_tick;

  assign in_tick   = (req.payload.req_type == REQ_TICK);
  assign req.ready = in_ready;

  kpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_tick   (in_tick),
    .in_ready  (in_ready),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kpi_datapath #(
    .STEPS_PER_SEGMENT (STEPS_PER_SEGMENT),
    .KEYFRAME_COUNT    (KEYFRAME_COUNT),
    .CHANNEL_COUNT     (CHANNEL_COUNT)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

`default_nettype wire
